// File: design/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int KEY_W        = 32;
    localparam int DATA_W       = 32;
    localparam int COUNT_OUT_W  = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } t_mode;

    typedef struct packed {
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] data;
    } t_entry;

    // Broadcast to every cell of the chain for the transfer in hand.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: design/spq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic signed [spq_pkg::DATA_W-1:0]  data_in;
    logic signed [spq_pkg::KEY_W-1:0]   priority_in;

    modport source (output valid, output mode, output data_in, output priority_in,
                    input ready);
    modport sink   (input valid, input mode, input data_in, input priority_in,
                    output ready);
endinterface

interface spq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [spq_pkg::DATA_W-1:0]    data_out;
    logic                                 was_empty;
    logic                                 was_full;
    logic [spq_pkg::COUNT_OUT_W-1:0]      count_out;

    modport source (output valid, output data_out, output was_empty, output was_full,
                    output count_out, input ready);
    modport sink   (input valid, input data_out, input was_empty, input was_full,
                    input count_out, output ready);
endinterface

`default_nettype wire

// File: design/stable_min_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// i_in      sink       mode, data_in, priority_in
// o_out     source     data_out, was_empty, was_full, count_out
//
// For every accepted item, the whole chain of cells compares
// against the broadcast key and shifts in the same edge, and the result is
// registered at that edge. A new item is taken whenever the output register
// is empty or being transferred, so the rate is one item per cycle.
// Synchronous active-low reset empties the queue and the output register;
// a stalled output holds its result and stops further input transfers.

module stable_min_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spq_in_if.sink     i_in,
    spq_out_if.source  o_out
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;
    logic                             r_out_valid;
    logic signed [spq_pkg::DATA_W-1:0] r_data_out;
    logic                             r_was_empty;
    logic                             r_was_full;
    logic [CW-1:0]                    r_count_res;

    logic                             accept;
    logic                             is_remove;
    logic                             full;
    logic                             empty;
    spq_pkg::t_cell_ctrl              ctrl;
    spq_pkg::t_entry                  new_entry;
    spq_pkg::t_entry                  entries [CAPACITY];
    logic [CAPACITY-1:0]              gt;
    logic [CW+spq_pkg::COUNT_OUT_W-1:0] count_wide;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign is_remove  = (i_in.mode == spq_pkg::MODE_REMOVE);
    assign full       = (r_count == CW'(CAPACITY));
    assign empty      = (r_count == '0);

    assign ctrl.ins = accept && !is_remove && !full;
    assign ctrl.rem = accept && is_remove && !empty;

    assign new_entry.key  = i_in.priority_in;
    assign new_entry.data = i_in.data_in;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            spq_pkg::t_entry prev_e;
            spq_pkg::t_entry next_e;
            logic            prev_gt;

            if (g == 0) begin : g_head
                assign prev_e  = new_entry;
                assign prev_gt = 1'b0;
            end else begin : g_body
                assign prev_e  = entries[g-1];
                assign prev_gt = gt[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign next_e = '0;
            end else begin : g_inner
                assign next_e = entries[g+1];
            end

            spq_cell u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (ctrl),
                .i_occ     (CW'(g) < r_count),
                .i_new     (new_entry),
                .i_prev    (prev_e),
                .i_prev_gt (prev_gt),
                .i_next    (next_e),
                .o_entry   (entries[g]),
                .o_gt      (gt[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (ctrl.ins) begin
            n_count = r_count + CW'(1);
        end else if (ctrl.rem) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data_out  <= ctrl.rem ? entries[0].data : '0;
            r_was_empty <= is_remove && empty;
            r_was_full  <= !is_remove && full;
            r_count_res <= n_count;
        end
    end

    assign count_wide      = {{spq_pkg::COUNT_OUT_W{1'b0}}, r_count_res};
    assign o_out.valid     = r_out_valid;
    assign o_out.data_out  = r_data_out;
    assign o_out.was_empty = r_was_empty;
    assign o_out.was_full  = r_was_full;
    assign o_out.count_out = count_wide[spq_pkg::COUNT_OUT_W-1:0];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("successful insert did not grow the queue");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_was_empty && r_was_full))
        else $error("empty and full flags raised together");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> ($signed(entries[0].key) <= $signed(entries[1].key)))
        else $error("head entries out of order");
`endif

endmodule

`default_nettype wire

// File: design/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire logic                i_clk,
    input  wire spq_pkg::t_cell_ctrl i_ctrl,
    input  wire logic                i_occ,
    input  wire spq_pkg::t_entry     i_new,
    input  wire spq_pkg::t_entry     i_prev,
    input  wire logic                i_prev_gt,
    input  wire spq_pkg::t_entry     i_next,
    output spq_pkg::t_entry          o_entry,
    output logic                     o_gt
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // An empty cell counts as holding a key above every other, so the new
    // entry lands just past the last entry whose key is less than or equal.
    assign o_gt    = !i_occ || ($signed(r_entry.key) > $signed(i_new.key));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (o_gt && !i_prev_gt) begin
                n_entry = i_new;
            end else if (o_gt) begin
                n_entry = i_prev;
            end
        end else if (i_ctrl.rem) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire
